// ===== src/fwdf_pkg.sv =====
package fwdf_pkg;

	// Field widths of a transaction.
	localparam int BIN_W  = 31;
	localparam int CNT_W  = 5;
	localparam int DIG_W  = 4;
	localparam int BYTE_W = 8;

	// Last step of the bit-serial conversion, one step per magnitude bit.
	localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(BIN_W - 1);

	// Display characters.
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_ALIGN,
		ST_EMIT
	} state_t;

	// Commands from the sequencer to the decimal shift register.
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
	} bcd_cmd_t;

endpackage

// ===== src/fixed_width_decimal_display_formatter_core.sv =====
// Formats a binary magnitude as a right-aligned decimal field for a character
// display. A transaction is taken when start is high while busy is low. Each
// output byte appears for exactly one cycle with strobe high and cannot be
// held off, so the receiver must take every byte as it comes. The cursor
// address byte, when there is one, appears in the cycle after start. The
// magnitude is then converted to decimal one bit a cycle, the digits are
// aligned one digit a cycle, and one byte follows per cycle: digits, plus a
// point and a minus sign where requested. A transaction with a digit count
// of zero returns at most the address byte and leaves busy low.
module fixed_width_decimal_display_formatter_core #(
	parameter int MAX_DIGITS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] magnitude,
	input  logic [3:0]  digit_count,
	input  logic [3:0]  fraction_digits,
	input  logic        is_negative,
	input  logic [7:0]  start_address,
	output logic        strobe,
	output logic [7:0]  out_byte,
	output logic        is_data,
	output logic        last
);

	fwdf_pkg::bcd_cmd_t            cmd;
	logic [fwdf_pkg::DIG_W-1:0]    top_digit;

	// Serial binary to decimal register.
	fwdf_bcd #(
		.NDIG(MAX_DIGITS)
	) u_bcd (
		.clk       (clk),
		.magnitude (magnitude),
		.cmd       (cmd),
		.top_digit (top_digit)
	);

	// Sequencer producing the byte stream.
	fwdf_seq #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.digit_count     (digit_count),
		.fraction_digits (fraction_digits),
		.is_negative     (is_negative),
		.start_address   (start_address),
		.top_digit       (top_digit),
		.cmd             (cmd),
		.busy            (busy),
		.strobe          (strobe),
		.out_byte        (out_byte),
		.is_data         (is_data),
		.last            (last)
	);

endmodule

// ===== src/fwdf_bcd.sv =====
module fwdf_bcd #(
	parameter int NDIG = 9
) (
	input  logic                          clk,
	input  logic [fwdf_pkg::BIN_W-1:0]    magnitude,
	input  fwdf_pkg::bcd_cmd_t            cmd,
	output logic [fwdf_pkg::DIG_W-1:0]    top_digit
);

	localparam int BCD_W = fwdf_pkg::DIG_W * NDIG;

	logic [fwdf_pkg::BIN_W-1:0] bin_q;
	logic [BCD_W-1:0]           bcd_q;
	logic [BCD_W-1:0]           adj;

	// Add three to every digit of five or more before the next shift.
	// Only the low NDIG digits are kept, which leaves the value modulo ten
	// to that many digits.
	always_comb begin
		for (int k = 0; k < NDIG; k++) begin
			if (bcd_q[k*4 +: 4] >= 4'd5) begin
				adj[k*4 +: 4] = bcd_q[k*4 +: 4] + 4'd3;
			end else begin
				adj[k*4 +: 4] = bcd_q[k*4 +: 4];
			end
		end
	end

	// Binary shifts out at the top into the decimal register, one bit a cycle;
	// afterwards the decimal register shifts out one digit a cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= magnitude;
			bcd_q <= '0;
		end else if (cmd.dabble) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[BCD_W-2:0], bin_q[fwdf_pkg::BIN_W-1]};
		end else if (cmd.shift) begin
			bcd_q <= bcd_q << fwdf_pkg::DIG_W;
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: fwdf_pkg::DIG_W];

endmodule

// ===== src/fwdf_seq.sv =====
module fwdf_seq #(
	parameter int MAX_DIGITS = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [3:0]                    digit_count,
	input  logic [3:0]                    fraction_digits,
	input  logic                          is_negative,
	input  logic [7:0]                    start_address,
	input  logic [fwdf_pkg::DIG_W-1:0]    top_digit,
	output fwdf_pkg::bcd_cmd_t            cmd,
	output logic                          busy,
	output logic                          strobe,
	output logic [7:0]                    out_byte,
	output logic                          is_data,
	output logic                          last
);

	localparam logic [3:0] MAX_D = 4'(MAX_DIGITS);

	fwdf_pkg::state_t state_q, state_d;
	logic [fwdf_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic       sign_q, sign_d;
	logic       lead_q, lead_d;
	logic       dot_q, dot_d;
	logic [3:0] d_q;
	logic [3:0] frac_q;
	logic [3:0] dsat;
	logic       take;
	logic       emit_v;
	logic [7:0] emit_byte;
	logic       emit_data;
	logic       emit_last;
	logic       pt_hit;
	logic       blank;
	logic       final_digit;
	logic       strobe_q;
	logic [7:0] byte_q;
	logic       data_q;
	logic       last_q;

	// Digit count saturated to the configured maximum.
	assign dsat = (digit_count > MAX_D) ? MAX_D : digit_count;

	// Position tests for the digit currently at the head of the register.
	assign pt_hit      = (cnt_q + {1'b0, frac_q}) == {1'b0, d_q};
	assign blank       = lead_q && (top_digit == '0)
		&& ((cnt_q + {1'b0, frac_q} + 5'd1) < {1'b0, d_q});
	assign final_digit = cnt_q == ({1'b0, d_q} - 5'd1);

	// Next state and the byte to present in the next cycle.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		sign_d    = sign_q;
		lead_d    = lead_q;
		dot_d     = dot_q;
		cmd       = '0;
		take      = 1'b0;
		emit_v    = 1'b0;
		emit_byte = fwdf_pkg::CH_SPACE;
		emit_data = 1'b1;
		emit_last = 1'b0;
		unique case (state_q)
			fwdf_pkg::ST_IDLE: begin
				if (start) begin
					take     = 1'b1;
					cmd.load = 1'b1;
					sign_d   = is_negative;
					lead_d   = 1'b1;
					dot_d    = 1'b0;
					cnt_d    = '0;
					if ((fraction_digits != 4'd0) || is_negative) begin
						emit_v    = 1'b1;
						emit_byte = start_address
							- {7'd0, (fraction_digits != 4'd0)}
							- {7'd0, is_negative};
						emit_data = 1'b0;
						emit_last = (dsat == 4'd0);
					end
					if (dsat != 4'd0) begin
						state_d = fwdf_pkg::ST_CONV;
					end
				end
			end
			fwdf_pkg::ST_CONV: begin
				cmd.dabble = 1'b1;
				cnt_d      = cnt_q + 5'd1;
				if (cnt_q == fwdf_pkg::CONV_LAST) begin
					cnt_d   = '0;
					state_d = (d_q == MAX_D) ? fwdf_pkg::ST_EMIT : fwdf_pkg::ST_ALIGN;
				end
			end
			fwdf_pkg::ST_ALIGN: begin
				cmd.shift = 1'b1;
				cnt_d     = cnt_q + 5'd1;
				if ((cnt_q + 5'd1) == {1'b0, MAX_D - d_q}) begin
					cnt_d   = '0;
					state_d = fwdf_pkg::ST_EMIT;
				end
			end
			fwdf_pkg::ST_EMIT: begin
				emit_v = 1'b1;
				if (!dot_q && pt_hit) begin
					emit_byte = fwdf_pkg::CH_DOT;
					dot_d     = 1'b1;
				end else if (!blank && sign_q) begin
					emit_byte = fwdf_pkg::CH_MINUS;
					sign_d    = 1'b0;
				end else begin
					emit_byte = blank ? fwdf_pkg::CH_SPACE
						: fwdf_pkg::CH_ZERO + {4'd0, top_digit};
					if (!blank) begin
						lead_d = 1'b0;
					end
					cmd.shift = 1'b1;
					dot_d     = 1'b0;
					cnt_d     = cnt_q + 5'd1;
					if (final_digit) begin
						emit_last = 1'b1;
						state_d   = fwdf_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = fwdf_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fwdf_pkg::ST_IDLE;
			cnt_q    <= '0;
			sign_q   <= 1'b0;
			lead_q   <= 1'b0;
			dot_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			sign_q   <= sign_d;
			lead_q   <= lead_d;
			dot_q    <= dot_d;
			strobe_q <= emit_v;
		end
	end

	// Transaction fields and the output byte.
	always_ff @(posedge clk) begin
		if (take) begin
			d_q    <= dsat;
			frac_q <= fraction_digits;
		end
		byte_q <= emit_byte;
		data_q <= emit_data;
		last_q <= emit_last;
	end

	assign busy     = (state_q != fwdf_pkg::ST_IDLE);
	assign strobe   = strobe_q;
	assign out_byte = byte_q;
	assign is_data  = data_q;
	assign last     = last_q;

endmodule
